FILE: rtl/core/tpp_pkg.sv
package tpp_pkg;

  typedef enum logic [3:0] {
    PH_TYPE  = 4'd0,
    PH_TAG0  = 4'd1,
    PH_LEN1  = 4'd2,
    PH_SIZE  = 4'd3,
    PH_TAG1  = 4'd4,
    PH_LEN2  = 4'd5,
    PH_NAME  = 4'd6,
    PH_DHIGH = 4'd7,
    PH_DLOW  = 4'd8,
    PH_DATA  = 4'd9,
    PH_SKIP  = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    K_SIZE    = 3'd0,
    K_NAME    = 3'd1,
    K_DLEN    = 3'd2,
    K_DATA    = 3'd3,
    K_END     = 3'd4,
    K_UNKNOWN = 3'd5,
    K_ERROR   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIZE_TAG  = 3'd1,
    ERR_SIZE_LEN  = 3'd2,
    ERR_NAME_TAG  = 3'd3,
    ERR_NAME_LEN  = 3'd4,
    ERR_DATA_LEN  = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_t;

  localparam logic [7:0] TAG_SIZE  = 8'd0;
  localparam logic [7:0] TAG_NAME  = 8'd1;
  localparam logic [7:0] TYPE_DATA = 8'd2;
  localparam logic [7:0] TYPE_END  = 8'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic        last;
    err_t        error;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: rtl/core/app_packet_tlv_parser_core.sv
// Byte-serial parser for a file-transfer packet format with a start control packet,
// data packets and an end-of-transfer packet.
// Input channel: in_valid, in_stall, in_pkt_byte and in_pkt_end, one packet byte per item,
// with in_pkt_end marking the final byte of each packet.
// Result channel: out_valid, out_stall, out_kind, out_value, out_last and out_error.
// Each input byte gives zero or one result item.
// Throughput is one byte per cycle while in_stall is low: the parser updates its state in
// the cycle that it accepts a byte and writes any result into a two-entry queue.
// A result is written into the queue when its byte is accepted, then moved into the output
// register, from which the receiver takes it.
// When the receiver stalls, the output register holds its item, the queue fills and
// in_stall rises once the queue is full; no item is lost.
// After reset the parser expects a start packet, the queue is empty and out_valid is low.
// MAX_SIZE_BYTES sets the longest accepted file-size field, in bytes.
module app_packet_tlv_parser_core #(
  parameter int MAX_SIZE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_pkt_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [63:0] out_value,
  output logic        out_last,
  output logic [2:0]  out_error
);
  import tpp_pkg::*;

  qstat_t  q_stat;
  logic    q_push;
  logic    q_pop;
  result_t q_wdata;
  result_t q_rdata;

  tpp_front #(
    .MAX_SIZE_BYTES(MAX_SIZE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pkt_byte(in_pkt_byte),
    .in_pkt_end (in_pkt_end),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  tpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .stat     (q_stat)
  );

  tpp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind (out_kind),
    .out_value(out_value),
    .out_last (out_last),
    .out_error(out_error)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("result written into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("result read from an empty queue");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && q_stat.empty) |=> !out_valid)
    else $error("output item appeared without a queued result");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == K_ERROR) == (out_error != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

FILE: rtl/core/tpp_front.sv
module tpp_front #(
  parameter int MAX_SIZE_BYTES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_pkt_byte,
  input  logic            in_pkt_end,
  input  tpp_pkg::qstat_t q_stat,
  output logic            q_push,
  output tpp_pkg::result_t q_data
);
  import tpp_pkg::*;

  localparam int AccW = MAX_SIZE_BYTES * 8;

  phase_t           phase_r, phase_nxt;
  logic             started_r, started_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic             accept;
  logic             have;
  result_t          res;
  phase_t           next;
  logic [15:0]      dlen;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign dlen     = {hi_r, in_pkt_byte};

  always_comb begin
    next        = PH_SKIP;
    have        = 1'b0;
    res         = '{kind: K_SIZE, value: 64'd0, last: 1'b0, error: ERR_NONE};
    started_nxt = started_r;
    left_nxt    = left_r;
    acc_nxt     = acc_r;
    hi_nxt      = hi_r;
    unique case (phase_r)
      PH_TYPE: begin
        if (!started_r) begin
          next = PH_TAG0;
        end else if (in_pkt_byte == TYPE_DATA) begin
          next = PH_DHIGH;
        end else if (in_pkt_byte == TYPE_END) begin
          have        = 1'b1;
          res.kind    = K_END;
          res.value   = {56'd0, in_pkt_byte};
          started_nxt = 1'b0;
        end else begin
          have      = 1'b1;
          res.kind  = K_UNKNOWN;
          res.value = {56'd0, in_pkt_byte};
        end
      end
      PH_TAG0: begin
        if (in_pkt_byte != TAG_SIZE) begin
          have      = 1'b1;
          res.kind  = K_ERROR;
          res.error = ERR_SIZE_TAG;
        end else begin
          next = PH_LEN1;
        end
      end
      PH_LEN1: begin
        if (in_pkt_byte == 8'd0 || in_pkt_byte > 8'(MAX_SIZE_BYTES)) begin
          have      = 1'b1;
          res.kind  = K_ERROR;
          res.error = ERR_SIZE_LEN;
        end else begin
          left_nxt = {8'd0, in_pkt_byte};
          acc_nxt  = '0;
          next     = PH_SIZE;
        end
      end
      PH_SIZE: begin
        acc_nxt  = AccW'({acc_r, in_pkt_byte});
        left_nxt = left_r - 16'd1;
        if (left_nxt == 16'd0) begin
          have      = 1'b1;
          res.kind  = K_SIZE;
          res.value = 64'(acc_nxt);
          next      = PH_TAG1;
        end else begin
          next = PH_SIZE;
        end
      end
      PH_TAG1: begin
        if (in_pkt_byte != TAG_NAME) begin
          have      = 1'b1;
          res.kind  = K_ERROR;
          res.error = ERR_NAME_TAG;
        end else begin
          next = PH_LEN2;
        end
      end
      PH_LEN2: begin
        if (in_pkt_byte == 8'd0) begin
          have      = 1'b1;
          res.kind  = K_ERROR;
          res.error = ERR_NAME_LEN;
        end else begin
          left_nxt = {8'd0, in_pkt_byte};
          next     = PH_NAME;
        end
      end
      PH_NAME: begin
        have      = 1'b1;
        res.kind  = K_NAME;
        res.value = {56'd0, in_pkt_byte};
        if (left_r <= 16'd1) begin
          left_nxt    = 16'd0;
          res.last    = 1'b1;
          started_nxt = 1'b1;
        end else begin
          left_nxt = left_r - 16'd1;
          next     = PH_NAME;
        end
      end
      PH_DHIGH: begin
        hi_nxt = in_pkt_byte;
        next   = PH_DLOW;
      end
      PH_DLOW: begin
        have = 1'b1;
        if (dlen == 16'd0) begin
          res.kind  = K_ERROR;
          res.error = ERR_DATA_LEN;
        end else begin
          res.kind  = K_DLEN;
          res.value = {48'd0, dlen};
          left_nxt  = dlen;
          next      = PH_DATA;
        end
      end
      PH_DATA: begin
        have      = 1'b1;
        res.kind  = K_DATA;
        res.value = {56'd0, in_pkt_byte};
        if (left_r <= 16'd1) begin
          left_nxt = 16'd0;
          res.last = 1'b1;
        end else begin
          left_nxt = left_r - 16'd1;
          next     = PH_DATA;
        end
      end
      default: begin
        next = PH_SKIP;
      end
    endcase
    if (in_pkt_end) begin
      if (next != PH_SKIP && next != PH_TYPE && !(have && res.kind == K_ERROR)) begin
        have = 1'b1;
        res  = '{kind: K_ERROR, value: 64'd0, last: 1'b0, error: ERR_TRUNCATED};
      end
      next = PH_TYPE;
    end
    phase_nxt = next;
  end

  assign q_push = accept && have;
  assign q_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TYPE;
      started_r <= 1'b0;
      left_r    <= 16'd0;
      acc_r     <= '0;
      hi_r      <= 8'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      started_r <= started_nxt;
      left_r    <= left_nxt;
      acc_r     <= acc_nxt;
      hi_r      <= hi_nxt;
    end
  end

endmodule

FILE: rtl/core/tpp_queue.sv
module tpp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpp_pkg::result_t push_data,
  input  logic             pop,
  output tpp_pkg::result_t pop_data,
  output tpp_pkg::qstat_t  stat
);
  import tpp_pkg::*;

  result_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/tpp_back.sv
module tpp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tpp_pkg::qstat_t  q_stat,
  input  tpp_pkg::result_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_kind,
  output logic [63:0]      out_value,
  output logic             out_last,
  output logic [2:0]       out_error
);
  import tpp_pkg::*;

  logic    valid_r;
  result_t res_r;
  logic    load;

  assign load      = !valid_r || !out_stall;
  assign q_pop     = load && !q_stat.empty;
  assign out_valid = valid_r;
  assign out_kind  = res_r.kind;
  assign out_value = res_r.value;
  assign out_last  = res_r.last;
  assign out_error = res_r.error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_data;
    end
  end

endmodule
